### rtl/hmpc_pkg.sv
// Shared types and constants for the hue-match pixel classifier.
// No dependencies; every other file refers to this package by scoped names.
package hmpc_pkg;

  localparam int COMP_W = 8;   // pixel component width
  localparam int HUE_W  = 9;   // signed hue / target width
  localparam int TOL_W  = 8;   // tolerance width
  localparam int Q_W    = 6;   // quotient bits, quotient never exceeds 42
  localparam int REM_W  = 14;  // dividend 42 * 255 fits in 14 bits
  localparam int DIST_W = 11;  // signed distance between target and hue

  localparam logic [5:0]        SECTOR     = 6'd42;
  localparam logic [7:0]        RED_BASE   = 8'd42;
  localparam logic [7:0]        GREEN_BASE = 8'd126;
  localparam logic [7:0]        BLUE_BASE  = 8'd210;
  localparam logic [HUE_W-1:0]  HUE_NONE   = 9'h1FF;
  localparam logic [HUE_W-1:0]  TARGET_RESET = 9'd0;
  localparam logic [TOL_W-1:0]  TOL_RESET  = 8'd30;
  localparam logic [HUE_W-1:0]  HUE_MAX    = 9'd252;

  typedef enum logic [0:0] {
    REG_TARGET_HUE    = 1'b0,
    REG_HUE_TOLERANCE = 1'b1
  } reg_idx_t;

  // Work carried from cell to cell along the divider chain.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [Q_W-1:0]    quot;
    logic [COMP_W-1:0] divisor;
    logic [7:0]        base;
    logic              neg;
    logic              no_hue;
  } div_t;

endpackage

### rtl/hmpc_if.sv
// Channel interfaces of the hue-match pixel classifier: pixel in, result out,
// register write. Depends on hmpc_pkg for field widths and the register index type.
interface hmpc_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [hmpc_pkg::COMP_W-1:0] red;
  logic [hmpc_pkg::COMP_W-1:0] green;
  logic [hmpc_pkg::COMP_W-1:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface hmpc_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [hmpc_pkg::HUE_W-1:0] hue;
  logic                             is_match;
  modport source (output valid, output hue, output is_match, input ready);
  modport sink   (input valid, input hue, input is_match, output ready);
endinterface

interface hmpc_cfg_if;
  logic                       valid;
  logic                       ready;
  hmpc_pkg::reg_idx_t         index;
  logic [hmpc_pkg::HUE_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/hmpc_front.sv
// First cell: max/min/delta, sector choice and the scaled dividend of one pixel.
// Depends on hmpc_pkg.
module hmpc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hmpc_pkg::COMP_W-1:0]  red,
  input  logic [hmpc_pkg::COMP_W-1:0]  green,
  input  logic [hmpc_pkg::COMP_W-1:0]  blue,
  output logic                         out_valid,
  input  logic                         out_ready,
  output hmpc_pkg::div_t               out_data
);

  logic [hmpc_pkg::COMP_W-1:0] hi;
  logic [hmpc_pkg::COMP_W-1:0] lo;
  logic [hmpc_pkg::COMP_W-1:0] delta;
  logic [hmpc_pkg::COMP_W+1:0] delta_x3;
  logic signed [hmpc_pkg::COMP_W:0] diff;
  logic [hmpc_pkg::COMP_W-1:0] mag;
  hmpc_pkg::div_t              data_next;

  always_comb begin
    hi = red;
    if (green > hi) hi = green;
    if (blue > hi) hi = blue;
    lo = red;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
    delta    = hi - lo;
    delta_x3 = {2'b00, delta} + {1'b0, delta, 1'b0};

    // Ties go to red, then green.
    if (red == hi) begin
      diff           = $signed({1'b0, green}) - $signed({1'b0, blue});
      data_next.base = hmpc_pkg::RED_BASE;
    end else if (green == hi) begin
      diff           = $signed({1'b0, blue}) - $signed({1'b0, red});
      data_next.base = hmpc_pkg::GREEN_BASE;
    end else begin
      diff           = $signed({1'b0, red}) - $signed({1'b0, green});
      data_next.base = hmpc_pkg::BLUE_BASE;
    end

    mag               = diff[hmpc_pkg::COMP_W] ? hmpc_pkg::COMP_W'(-diff)
                                               : diff[hmpc_pkg::COMP_W-1:0];
    data_next.neg     = diff[hmpc_pkg::COMP_W];
    data_next.rem     = {{(hmpc_pkg::REM_W-hmpc_pkg::COMP_W){1'b0}}, mag}
                      * {{(hmpc_pkg::REM_W-6){1'b0}}, hmpc_pkg::SECTOR};
    data_next.quot    = '0;
    data_next.divisor = delta;
    data_next.no_hue  = (delta_x3 <= {2'b00, hi});
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### rtl/hmpc_div_cell.sv
// One restoring-division cell: settles one quotient bit per beat.
// Depends on hmpc_pkg.
module hmpc_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  hmpc_pkg::div_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output hmpc_pkg::div_t  out_data
);

  logic [hmpc_pkg::REM_W-1:0] trial;
  logic                       fits;
  hmpc_pkg::div_t             data_next;

  always_comb begin
    trial = {{(hmpc_pkg::REM_W-hmpc_pkg::COMP_W){1'b0}}, in_data.divisor} << SHIFT;
    fits  = (in_data.rem >= trial);
    data_next      = in_data;
    data_next.rem  = fits ? in_data.rem - trial : in_data.rem;
    data_next.quot = {in_data.quot[hmpc_pkg::Q_W-2:0], fits};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### rtl/hmpc_back.sv
// Last cell: signed hue from sector base and quotient, tolerance match, output register.
// Depends on hmpc_pkg.
module hmpc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hmpc_pkg::div_t              in_data,
  input  logic [hmpc_pkg::HUE_W-1:0]  target_hue,
  input  logic [hmpc_pkg::TOL_W-1:0]  hue_tolerance,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hmpc_pkg::HUE_W-1:0]  hue,
  output logic                        is_match
);

  logic [hmpc_pkg::HUE_W-1:0]  hue_calc;
  logic [hmpc_pkg::HUE_W-1:0]  hue_next;
  logic [hmpc_pkg::DIST_W-1:0] gap;
  logic [hmpc_pkg::DIST_W-1:0] dist_abs;
  logic                        match_next;

  always_comb begin
    hue_calc = in_data.neg
      ? {1'b0, in_data.base} - {{(hmpc_pkg::HUE_W-hmpc_pkg::Q_W){1'b0}}, in_data.quot}
      : {1'b0, in_data.base} + {{(hmpc_pkg::HUE_W-hmpc_pkg::Q_W){1'b0}}, in_data.quot};
    hue_next = in_data.no_hue ? hmpc_pkg::HUE_NONE : hue_calc;
    gap      = {{(hmpc_pkg::DIST_W-hmpc_pkg::HUE_W){target_hue[hmpc_pkg::HUE_W-1]}},
                target_hue}
             - {{(hmpc_pkg::DIST_W-hmpc_pkg::HUE_W){1'b0}}, hue_calc};
    dist_abs = gap[hmpc_pkg::DIST_W-1] ? -gap : gap;
    match_next = !in_data.no_hue &&
      (dist_abs < {{(hmpc_pkg::DIST_W-hmpc_pkg::TOL_W){1'b0}}, hue_tolerance});
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hue      <= hue_next;
      is_match <= match_next;
    end
  end

endmodule

### rtl/hue_match_pixel_classifier_core.sv
// Hue-match pixel classifier: takes one RGB pixel per beat and returns its hue
// (0..252, or -1 when saturation is too low) and a flag set when the hue lies
// strictly within hue_tolerance of target_hue, one pixel per clock while
// res.ready holds. Path: a front cell, a row of 6 restoring-division cells
// (one quotient bit each) and the output register. Every cell holds its beat
// under backpressure and fills bubbles; pixels enter until every cell is full.
// Registers: index 0 target_hue (reset 0), index 1 hue_tolerance (reset 30);
// write them only while no pixel is in flight. Depends on hmpc_pkg and hmpc_if.
module hue_match_pixel_classifier_core (
  input  logic                  clk,
  input  logic                  rst,
  hmpc_pixel_if.sink            pix,
  hmpc_result_if.source         res,
  hmpc_cfg_if.sink              cfg
);

  localparam int NCELL = hmpc_pkg::Q_W;

  logic [hmpc_pkg::HUE_W-1:0] target_hue;
  logic [hmpc_pkg::TOL_W-1:0] hue_tolerance;

  logic            stg_valid [NCELL+1];
  logic            stg_ready [NCELL+1];
  hmpc_pkg::div_t  stg_data  [NCELL+1];
  logic [hmpc_pkg::HUE_W-1:0] res_hue;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_hue    <= hmpc_pkg::TARGET_RESET;
      hue_tolerance <= hmpc_pkg::TOL_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        hmpc_pkg::REG_TARGET_HUE:    target_hue    <= cfg.data;
        hmpc_pkg::REG_HUE_TOLERANCE: hue_tolerance <= cfg.data[hmpc_pkg::TOL_W-1:0];
      endcase
    end
  end

  hmpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .red       (pix.red),
    .green     (pix.green),
    .blue      (pix.blue),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_data  (stg_data[0])
  );

  // Quotient bits settle MSB first down the row.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    hmpc_div_cell #(
      .SHIFT (NCELL - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_data   (stg_data[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_data  (stg_data[i+1])
    );
  end

  hmpc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (stg_valid[NCELL]),
    .in_ready      (stg_ready[NCELL]),
    .in_data       (stg_data[NCELL]),
    .target_hue    (target_hue),
    .hue_tolerance (hue_tolerance),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .hue           (res_hue),
    .is_match      (res.is_match)
  );

  assign res.hue = $signed(res_hue);

  a_no_hue_no_match: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res_hue == hmpc_pkg::HUE_NONE) |-> !res.is_match)
    else $error("no-hue result flagged as match");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res_hue != hmpc_pkg::HUE_NONE) |-> (res_hue <= hmpc_pkg::HUE_MAX))
    else $error("hue out of range");

  a_zero_tol: assert property (@(posedge clk) disable iff (rst)
    (res.valid && hue_tolerance == '0) |-> !res.is_match)
    else $error("match with zero tolerance");

  a_front_free: assert property (@(posedge clk) disable iff (rst)
    !stg_valid[0] |-> pix.ready)
    else $error("input stalled with empty front cell");

endmodule
